@@ rtl/infix_arith_expr_evaluator_core_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef INFIX_ARITH_EXPR_EVALUATOR_CORE_MACROS_SVH
`define INFIX_ARITH_EXPR_EVALUATOR_CORE_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define IAEE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checks a property in the cycle that follows a reset edge.
`define IAEE_ASSERT_AFTER_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) rst |=> prop) else $error(msg);

`endif

@@ rtl/iaee_pkg.sv @@
`default_nettype none
package iaee_pkg;

  localparam int OPND_W = 48;
  localparam int OUT_W  = 64;

  localparam logic signed [OPND_W-1:0] OPND_MAX = {1'b0, {(OPND_W-1){1'b1}}};
  localparam logic signed [OPND_W-1:0] OPND_MIN = {1'b1, {(OPND_W-1){1'b0}}};

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  localparam logic signed [8:0] DIGIT_BASE = 9'sd48;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_MUL   = 2'd1,
    OP_DIV   = 2'd2
  } term_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_RUN,
    ST_TERM,
    ST_EMIT
  } state_t;

  typedef enum logic {
    SU_MUL,
    SU_DIV
  } su_mode_t;

  typedef struct packed {
    logic     start;
    su_mode_t mode;
    logic     neg;
  } su_ctrl_t;

  typedef struct packed {
    logic done;
    logic clamp;
  } su_stat_t;

endpackage
`default_nettype wire

@@ rtl/iaee_serial_unit.sv @@
`default_nettype none
module iaee_serial_unit import iaee_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  su_ctrl_t                      ctrl,
  input  logic [VALUE_WIDTH-1:0]        mt,
  input  logic [OPND_W-1:0]             mn,
  output su_stat_t                      stat,
  output logic signed [VALUE_WIDTH-1:0] term
);

  localparam int AW = (VALUE_WIDTH > OPND_W) ? VALUE_WIDTH + 1 : OPND_W + 1;
  localparam int NW = ((VALUE_WIDTH > OPND_W - 1) ? VALUE_WIDTH : OPND_W - 1) + 1;
  localparam int MW = (AW > NW) ? AW : NW;
  localparam int CW = $clog2(NW + 1);

  logic                   busy;
  logic                   done;
  logic [CW-1:0]          cnt;
  su_mode_t               mode;
  logic                   neg;
  logic                   ovf;
  logic [NW-1:0]          sr;
  logic [AW-1:0]          acc;
  logic [VALUE_WIDTH-1:0] mt_r;
  logic [OPND_W-1:0]      mn_r;

  logic [AW-1:0]          bound_a;
  logic [AW-1:0]          mul_sum;
  logic                   mul_over;
  logic [AW-1:0]          rem_sh;
  logic [AW-1:0]          rem_sub;
  logic                   rem_ge;
  logic [MW-1:0]          mag_w;
  logic [MW-1:0]          bound_w;
  logic [MW-1:0]          sat_w;
  logic                   over;
  logic [VALUE_WIDTH-1:0] low;

  // Multiply runs MSB first over the operand bits, divide is restoring with one
  // quotient bit shifted into the dividend register per cycle.
  always_comb begin
    bound_a  = (AW'(1) << (VALUE_WIDTH - 1)) - AW'(!neg);
    mul_sum  = {acc[AW-2:0], 1'b0} + AW'(sr[NW-1] ? mt_r : '0);
    mul_over = mul_sum > bound_a;
    rem_sh   = {acc[AW-2:0], sr[NW-1]};
    rem_ge   = rem_sh >= AW'(mn_r);
    rem_sub  = rem_sh - AW'(mn_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !ctrl.start && busy && (cnt == CW'(1));
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= (ctrl.mode == SU_MUL) ? CW'(OPND_W) : CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode <= ctrl.mode;
      neg  <= ctrl.neg;
      acc  <= '0;
      ovf  <= 1'b0;
      mt_r <= mt;
      mn_r <= mn;
      if (ctrl.mode == SU_MUL) begin
        sr <= NW'(mn) << (NW - OPND_W);
      end else begin
        sr <= NW'(mt) + NW'(mn >> 1);
      end
    end else if (busy) begin
      unique case (mode)
        SU_MUL: begin
          sr <= sr << 1;
          if (mul_over) begin
            acc <= bound_a;
            ovf <= 1'b1;
          end else begin
            acc <= mul_sum;
          end
        end
        SU_DIV: begin
          sr  <= {sr[NW-2:0], rem_ge};
          acc <= rem_ge ? rem_sub : rem_sh;
        end
      endcase
    end
  end

  always_comb begin
    mag_w   = (mode == SU_MUL) ? MW'(acc) : MW'(sr);
    bound_w = (MW'(1) << (VALUE_WIDTH - 1)) - MW'(!neg);
    over    = ((mode == SU_MUL) && ovf) || (mag_w > bound_w);
    sat_w   = over ? bound_w : mag_w;
    low     = sat_w[VALUE_WIDTH-1:0];
    term    = neg ? -low : low;
    stat.done  = done;
    stat.clamp = over;
  end

endmodule
`default_nettype wire

@@ rtl/infix_arith_expr_evaluator_core.sv @@
// Evaluates an infix expression of + - * / fed one byte per transfer, with * and
// / binding tighter than + and -, and returns one signed fixed-point value with
// FRAC_BITS fraction bits plus the divide-by-zero and saturation flags after the
// byte marked last_char. Bytes that are not operators add a digit of value byte
// minus 48 to the operand. A digit byte is taken in the idle state. An operator
// byte closes the operand, through the shared multiply/divide unit when it closes
// a multiply or a divide by a nonzero operand, and a + or - byte then closes the
// term; the last byte adds one more operand close, a term close and the load of
// the result register. The multiply/divide unit handles one operand bit or one
// quotient bit per cycle. The result register lets the next expression start
// while a result still waits to be taken.
`default_nettype none
module infix_arith_expr_evaluator_core import iaee_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_stall,
  input  logic [7:0]              char_code,
  input  logic                    last_char,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [OUT_W-1:0] value,
  output logic                    div_by_zero,
  output logic                    saturated
);

  localparam int DSUM_W = OPND_W + 5;
  localparam int SW     = OPND_W + FRAC_BITS;
  localparam int CMPW   = (SW > VALUE_WIDTH) ? SW : VALUE_WIDTH;
  localparam int SUMW   = VALUE_WIDTH + 1;

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  state_t state, state_next;

  logic signed [OPND_W-1:0]      opnd;
  logic signed [VALUE_WIDTH-1:0] term;
  logic signed [VALUE_WIDTH-1:0] sum;
  term_op_t                      pend_op;
  logic                          pend_minus;
  logic                          zero_seen;
  logic                          clamp_seen;
  logic                          last_r;
  logic                          kind_addsub;
  logic                          kind_minus;
  logic                          kind_div;
  logic                          fin;

  logic                          accept;
  logic                          in_addsub;
  logic                          in_muldiv;
  logic                          in_digit;
  logic                          out_free;
  logic                          direct;
  logic                          zdiv;
  logic                          to_term;
  logic                          opnd_done;
  logic                          term_done;
  logic                          set_fin;
  logic                          emit_load;

  logic signed [8:0]             dval;
  logic signed [DSUM_W-1:0]      opnd_x;
  logic signed [DSUM_W-1:0]      dig_sum;
  logic [DSUM_W-OPND_W:0]        dig_top;
  logic                          dig_over;
  logic signed [OPND_W-1:0]      dig_val;

  logic                          opnd_neg;
  logic [OPND_W-1:0]             mn;
  logic [VALUE_WIDTH-1:0]        mt;
  logic [CMPW-1:0]               st_mag;
  logic [CMPW-1:0]               st_bound;
  logic [CMPW-1:0]               st_sat;
  logic                          st_over;
  logic [VALUE_WIDTH-1:0]        st_low;
  logic signed [VALUE_WIDTH-1:0] st_term;

  logic signed [VALUE_WIDTH-1:0] opnd_term;
  logic                          opnd_clamp;

  logic signed [SUMW-1:0]        sum_x;
  logic                          sum_over;
  logic signed [VALUE_WIDTH-1:0] sum_new;

  su_ctrl_t                      su_ctrl;
  su_stat_t                      su_stat;
  logic signed [VALUE_WIDTH-1:0] su_term;

  assign in_addsub = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign in_muldiv = (char_code == CH_MUL) || (char_code == CH_DIV);
  assign in_digit  = !in_addsub && !in_muldiv;
  assign accept    = char_valid && !char_stall;
  assign out_free  = !result_valid || !result_stall;

  always_comb begin
    dval     = $signed({1'b0, char_code}) - DIGIT_BASE;
    opnd_x   = DSUM_W'(opnd);
    dig_sum  = (opnd_x <<< 3) + (opnd_x <<< 1) + DSUM_W'(dval);
    dig_top  = dig_sum[DSUM_W-1:OPND_W-1];
    dig_over = !((&dig_top) || !(|dig_top));
    if (dig_over) begin
      dig_val = dig_sum[DSUM_W-1] ? OPND_MIN : OPND_MAX;
    end else begin
      dig_val = dig_sum[OPND_W-1:0];
    end
  end

  always_comb begin
    opnd_neg = opnd[OPND_W-1];
    mn       = opnd_neg ? -opnd : opnd;
    mt       = term[VALUE_WIDTH-1] ? -term : term;
    st_mag   = CMPW'(mn) << FRAC_BITS;
    st_bound = (CMPW'(1) << (VALUE_WIDTH - 1)) - CMPW'(!opnd_neg);
    st_over  = st_mag > st_bound;
    st_sat   = st_over ? st_bound : st_mag;
    st_low   = st_sat[VALUE_WIDTH-1:0];
    st_term  = opnd_neg ? -st_low : st_low;
  end

  assign zdiv   = (pend_op == OP_DIV) && (mn == '0);
  assign direct = !((pend_op == OP_MUL) || ((pend_op == OP_DIV) && (mn != '0)));

  always_comb begin
    if (state == ST_RUN) begin
      opnd_term  = su_term;
      opnd_clamp = su_stat.clamp;
    end else if (zdiv) begin
      opnd_term  = '0;
      opnd_clamp = 1'b0;
    end else begin
      opnd_term  = st_term;
      opnd_clamp = st_over;
    end
  end

  always_comb begin
    sum_x    = pend_minus ? (SUMW'(sum) - SUMW'(term)) : (SUMW'(sum) + SUMW'(term));
    sum_over = sum_x[SUMW-1] != sum_x[SUMW-2];
    if (sum_over) begin
      sum_new = sum_x[SUMW-1] ? VMIN : VMAX;
    end else begin
      sum_new = sum_x[VALUE_WIDTH-1:0];
    end
  end

  assign to_term = fin || kind_addsub;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (!in_digit || last_char)) begin
          state_next = ST_OPND;
        end
      end
      ST_OPND: begin
        if (!direct) begin
          state_next = ST_RUN;
        end else if (to_term) begin
          state_next = ST_TERM;
        end else begin
          state_next = last_r ? ST_OPND : ST_IDLE;
        end
      end
      ST_RUN: begin
        if (su_stat.done) begin
          if (to_term) begin
            state_next = ST_TERM;
          end else begin
            state_next = last_r ? ST_OPND : ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        if (fin) begin
          state_next = ST_EMIT;
        end else begin
          state_next = last_r ? ST_OPND : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    char_stall    = 1'b1;
    su_ctrl.start = 1'b0;
    su_ctrl.mode  = (pend_op == OP_DIV) ? SU_DIV : SU_MUL;
    su_ctrl.neg   = term[VALUE_WIDTH-1] ^ opnd_neg;
    opnd_done     = 1'b0;
    term_done     = 1'b0;
    emit_load     = 1'b0;
    unique case (state)
      ST_IDLE: char_stall = 1'b0;
      ST_OPND: begin
        su_ctrl.start = !direct;
        opnd_done     = direct;
      end
      ST_RUN:  opnd_done = su_stat.done;
      ST_TERM: term_done = 1'b1;
      ST_EMIT: emit_load = out_free;
      default: char_stall = 1'b1;
    endcase
    set_fin = (opnd_done && !to_term && last_r) || (term_done && !fin && last_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opnd        <= '0;
      term        <= '0;
      sum         <= '0;
      pend_op     <= OP_START;
      pend_minus  <= 1'b0;
      zero_seen   <= 1'b0;
      clamp_seen  <= 1'b0;
      fin         <= 1'b0;
      last_r      <= 1'b0;
      kind_addsub <= 1'b0;
      kind_minus  <= 1'b0;
      kind_div    <= 1'b0;
    end else begin
      if (accept) begin
        last_r      <= last_char;
        kind_addsub <= in_addsub;
        kind_minus  <= char_code == CH_MINUS;
        kind_div    <= char_code == CH_DIV;
        fin         <= in_digit && last_char;
        if (in_digit) begin
          opnd <= dig_val;
          if (dig_over) begin
            clamp_seen <= 1'b1;
          end
        end
      end
      if (opnd_done) begin
        opnd <= '0;
        term <= opnd_term;
        if (opnd_clamp) begin
          clamp_seen <= 1'b1;
        end
        if ((state == ST_OPND) && zdiv) begin
          zero_seen <= 1'b1;
        end
        if (!to_term) begin
          pend_op <= kind_div ? OP_DIV : OP_MUL;
        end
      end
      if (term_done) begin
        sum  <= sum_new;
        term <= '0;
        if (sum_over) begin
          clamp_seen <= 1'b1;
        end
        if (!fin) begin
          pend_minus <= kind_minus;
          pend_op    <= OP_START;
        end
      end
      if (set_fin) begin
        fin <= 1'b1;
      end
      if (emit_load) begin
        opnd       <= '0;
        term       <= '0;
        sum        <= '0;
        pend_op    <= OP_START;
        pend_minus <= 1'b0;
        zero_seen  <= 1'b0;
        clamp_seen <= 1'b0;
        fin        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      value       <= zero_seen ? '0 : OUT_W'(sum);
      div_by_zero <= zero_seen;
      saturated   <= clamp_seen;
    end
  end

  iaee_serial_unit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_serial (
    .clk  (clk),
    .rst  (rst),
    .ctrl (su_ctrl),
    .mt   (mt),
    .mn   (mn),
    .stat (su_stat),
    .term (su_term)
  );

endmodule
`default_nettype wire

@@ rtl/iaee_checker.sv @@
`default_nettype none
`include "infix_arith_expr_evaluator_core_macros.svh"
module iaee_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_valid,
  input logic        char_stall,
  input logic        last_char,
  input logic        result_valid,
  input logic        result_stall,
  input logic [63:0] value,
  input logic        div_by_zero
);

  // A result waiting on a stall keeps its value.
  `IAEE_ASSERT(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(value), "result changed while stalled")

  // A failed division always reports a value of zero.
  `IAEE_ASSERT(a_zero_value, clk, rst, result_valid && div_by_zero |-> value == 64'd0, "nonzero value with divide by zero")

  // The last byte of an expression always starts the closing sequence.
  `IAEE_ASSERT(a_last_busy, clk, rst, char_valid && !char_stall && last_char |=> char_stall, "no closing work after the last byte")

  // Reset leaves no result pending and the input open.
  `IAEE_ASSERT_AFTER_RST(a_reset_clear, clk, rst, !result_valid && !char_stall, "state not clear after reset")

endmodule

bind infix_arith_expr_evaluator_core iaee_checker u_iaee_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

class expr_scoreboard;
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 64;
  localparam longint OPND_HI = (64'sd1 <<< 47) - 1;
  localparam longint OPND_LO = -OPND_HI - 1;

  typedef struct {
    longint value;
    bit     dz;
    bit     sat;
  } expr_result_t;

  expr_result_t        want_q[$];
  longint              sum_fx;
  longint              term_fx;
  longint              opnd;
  bit                  minus_pending;
  iaee_pkg::term_op_t  term_op;
  bit                  zdiv;
  bit                  clamp;
  int                  errors;
  int                  checked;
  int                  dz_count;
  int                  sat_count;
  int                  exprs;

  function new();
    clear_expr();
    errors    = 0;
    checked   = 0;
    dz_count  = 0;
    sat_count = 0;
    exprs     = 0;
  endfunction

  function void clear_expr();
    sum_fx        = 0;
    term_fx       = 0;
    opnd          = 0;
    minus_pending = 1'b0;
    term_op       = iaee_pkg::OP_START;
    zdiv          = 1'b0;
    clamp         = 1'b0;
  endfunction

  function longint unsigned mag(longint v);
    longint unsigned u;
    u = v;
    return (v < 0) ? (64'd0 - u) : u;
  endfunction

  function longint unsigned limit_for(bit neg);
    longint unsigned hi;
    hi = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    return neg ? hi + 64'd1 : hi;
  endfunction

  function longint from_mag(bit neg, longint unsigned m);
    longint t;
    if (m > limit_for(neg)) begin
      m     = limit_for(neg);
      clamp = 1'b1;
    end
    if (m == 0) return 0;
    t = longint'(m - 64'd1);
    if (neg) return -t - 1;
    return longint'(m);
  endfunction

  function longint sat_add(longint a, longint b);
    longint mx, mn;
    mx = longint'(limit_for(1'b0));
    mn = -mx - 1;
    if (b > 0 && a > mx - b) begin clamp = 1'b1; return mx; end
    if (b < 0 && a < mn - b) begin clamp = 1'b1; return mn; end
    return a + b;
  endfunction

  function longint sat_sub(longint a, longint b);
    longint mx, mn;
    mx = longint'(limit_for(1'b0));
    mn = -mx - 1;
    if (b < 0 && a > mx + b) begin clamp = 1'b1; return mx; end
    if (b > 0 && a < mn + b) begin clamp = 1'b1; return mn; end
    return a - b;
  endfunction

  function void close_operand();
    longint unsigned mn, mt;
    bit nneg, tneg, neg;
    mn   = mag(opnd);
    mt   = mag(term_fx);
    nneg = opnd < 0;
    tneg = term_fx < 0;
    neg  = tneg ^ nneg;
    case (term_op)
      iaee_pkg::OP_MUL: begin
        if (mn != 0 && mt > limit_for(neg) / mn)
          term_fx = from_mag(neg, limit_for(neg) + 64'd1);
        else
          term_fx = from_mag(neg, mt * mn);
      end
      iaee_pkg::OP_DIV: begin
        if (mn == 0) begin
          zdiv    = 1'b1;
          term_fx = 0;
        end else begin
          term_fx = from_mag(neg, (mt + mn / 64'd2) / mn);
        end
      end
      default: begin
        if (mn > (limit_for(nneg) >> FRAC_BITS))
          term_fx = from_mag(nneg, limit_for(nneg) + 64'd1);
        else
          term_fx = from_mag(nneg, mn << FRAC_BITS);
      end
    endcase
    opnd = 0;
  endfunction

  function void close_term();
    sum_fx  = minus_pending ? sat_sub(sum_fx, term_fx) : sat_add(sum_fx, term_fx);
    term_fx = 0;
  endfunction

  function void note_input(bit [7:0] c, bit last);
    longint v;
    expr_result_t r;
    if (c == iaee_pkg::CH_PLUS || c == iaee_pkg::CH_MINUS) begin
      close_operand();
      close_term();
      minus_pending = (c == iaee_pkg::CH_MINUS);
      term_op       = iaee_pkg::OP_START;
    end else if (c == iaee_pkg::CH_MUL || c == iaee_pkg::CH_DIV) begin
      close_operand();
      term_op = (c == iaee_pkg::CH_MUL) ? iaee_pkg::OP_MUL : iaee_pkg::OP_DIV;
    end else begin
      v = opnd * 10 + (longint'(c) - 48);
      if (v > OPND_HI) begin v = OPND_HI; clamp = 1'b1; end
      if (v < OPND_LO) begin v = OPND_LO; clamp = 1'b1; end
      opnd = v;
    end
    if (last) begin
      close_operand();
      close_term();
      r.value = zdiv ? 0 : sum_fx;
      r.dz    = zdiv;
      r.sat   = clamp;
      want_q.push_back(r);
      exprs++;
      clear_expr();
    end
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("tb: mismatch: %s", what);
  endtask

  task check_result(logic signed [63:0] v, logic dz, logic sat);
    expr_result_t w;
    if (want_q.size() == 0) begin
      report($sformatf("result %0d with no expression pending", v));
      return;
    end
    w = want_q.pop_front();
    checked++;
    if (w.dz) dz_count++;
    if (w.sat) sat_count++;
    if (v !== w.value)
      report($sformatf("value got %0d, want %0d", v, w.value));
    if (dz !== w.dz)
      report($sformatf("div_by_zero got %b, want %b", dz, w.dz));
    if (sat !== w.sat)
      report($sformatf("saturated got %b, want %b", sat, w.sat));
  endtask

  function int pending();
    return want_q.size();
  endfunction
endclass

module tb;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_BYTES  = 255;
  localparam int DRAIN_LIMIT  = 100000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                char_valid = 1'b0;
  logic                                char_stall;
  logic [7:0]                          char_code = 8'h30;
  logic                                last_char = 1'b0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic signed [iaee_pkg::OUT_W-1:0]   value;
  logic                                div_by_zero;
  logic                                saturated;

  expr_scoreboard sb = new();
  bit [7:0]       expr_bytes[$];
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             bytes_sent = 0;
  int             hold_req = 0;
  int             hold_ack = 0;
  int unsigned    hold_left = 0;

  infix_arith_expr_evaluator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .div_by_zero  (div_by_zero),
    .saturated    (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // The receiver samples each result transfer and runs the long hold-off on request.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      sb.check_result(value, div_by_zero, saturated);
    end
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    last_char  <= last;
    @(posedge clk);
    while (char_stall !== 1'b0) @(posedge clk);
    sb.note_input(c, last);
    bytes_sent++;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_bytes.size(); i++) begin
      send_char(expr_bytes[i], i == expr_bytes.size() - 1);
    end
    expr_bytes.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
  endtask

  task automatic push_op();
    case ($urandom_range(3))
      0: expr_bytes.push_back(iaee_pkg::CH_PLUS);
      1: expr_bytes.push_back(iaee_pkg::CH_MINUS);
      2: expr_bytes.push_back(iaee_pkg::CH_MUL);
      default: expr_bytes.push_back(iaee_pkg::CH_DIV);
    endcase
  endtask

  task automatic build_random_expr();
    int shape, n_opnds, n_dig, r;
    shape = $urandom_range(99);
    if (shape < 85) begin
      n_opnds = $urandom_range(1, 5);
      for (int i = 0; i < n_opnds; i++) begin
        if (i > 0) push_op();
        r = $urandom_range(99);
        if (r < 6) n_dig = 0;
        else if (r < 90) n_dig = $urandom_range(1, 3);
        else n_dig = $urandom_range(9, 16);
        for (int d = 0; d < n_dig; d++) begin
          if ($urandom_range(99) < 4) expr_bytes.push_back(8'($urandom_range(255)));
          else expr_bytes.push_back(8'h30 + 8'($urandom_range(9)));
        end
      end
      if ($urandom_range(99) < 6 || expr_bytes.size() == 0) push_op();
    end else begin
      n_opnds = $urandom_range(1, 6);
      for (int i = 0; i < n_opnds; i++) begin
        if ($urandom_range(99) < 30) push_op();
        else expr_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int phase_start, waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    expr_bytes.push_back(8'hFF);
    send_expr();
    expr_bytes.push_back(8'h00);
    send_expr();
    push_text("9*7");
    send_expr();
    push_text("8/0+3");
    send_expr();
    push_text("7/2-");
    send_expr();
    repeat (13) expr_bytes.push_back(8'hFF);
    push_text("*9");
    send_expr();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      if (ph == 0) hold_req <= hold_req + 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_expr();
        send_expr();
      end
    end
    char_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (200) @(posedge clk);

    $display("tb: %0d expressions in %0d bytes, four idling phases, one long result hold-off",
             sb.exprs, bytes_sent);
    $display("tb: %0d results checked, %0d with divide by zero, %0d saturated",
             sb.checked, sb.dz_count, sb.sat_count);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/iaee_pkg.sv
rtl/iaee_serial_unit.sv
rtl/infix_arith_expr_evaluator_core.sv
rtl/iaee_checker.sv
dv/tb.sv
